// ===== src/stereo_feedback_echo_defines.svh =====
// Assertion macros for the stereo feedback echo.
// Included by the top level; no other dependencies.
`ifndef STEREO_FEEDBACK_ECHO_DEFINES_SVH
`define STEREO_FEEDBACK_ECHO_DEFINES_SVH
`ifndef SYNTHESIS
`define SFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfe: assertion failed");
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfe: assertion failed");
`else
`define SFE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/sfe_pkg.sv =====
// Shared constants for the stereo feedback echo: field widths,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package sfe_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TARGET_W    = 24;
	localparam int GAIN_W      = 16;
	localparam int COEFF_W     = 25;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 3;
	localparam int DELAY_W     = 40;	// Q16.24

	localparam int LINE_DEPTH_DEFAULT = 65536;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_DELAY_TARGET  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_DELAY_TARGET = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX            = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GLIDE_COEFF        = 3'd4;

	// reset values
	localparam logic [TARGET_W-1:0] DELAY_TARGET_RST  = 24'd3072000;
	localparam logic [GAIN_W-1:0]   FEEDBACK_GAIN_RST = 16'd16384;
	localparam logic [GAIN_W-1:0]   WET_MIX_RST       = 16'd16384;
	localparam logic [COEFF_W-1:0]  GLIDE_COEFF_RST   = 25'd1748;

	localparam logic [TARGET_W-1:0] TARGET_MIN = 24'd256;
	localparam logic [GAIN_W:0]     ONE_Q15    = 17'h08000;
	localparam logic [COEFF_W-1:0]  ONE_Q24    = 25'h1000000;

endpackage

// ===== src/sfe_in_if.sv =====
// Input frame channel: valid/ready plus one stereo input frame.
// Depends on sfe_pkg for the sample width.
`timescale 1ns / 1ps

interface sfe_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [sfe_pkg::SAMPLE_W-1:0] left_in;
	logic signed [sfe_pkg::SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== src/sfe_out_if.sv =====
// Output frame channel: valid/ready plus one mixed stereo frame.
// Depends on sfe_pkg for the sample width.
`timescale 1ns / 1ps

interface sfe_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [sfe_pkg::SAMPLE_W-1:0] left_out;
	logic signed [sfe_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/stereo_feedback_echo.sv =====
// Stereo feedback echo: gliding fractional delay per channel, feedback and dry/wet mix.
// Depends on sfe_pkg, sfe_in_if, sfe_out_if and stereo_feedback_echo_defines.svh.
`timescale 1ns / 1ps
`include "stereo_feedback_echo_defines.svh"

// Channel    Role        Handshake        Payload
// samples    input       valid/ready      left_in, right_in (s16 Q1.15)
// mixed      output      valid/ready      left_out, right_out (s16 Q1.15)
// cfg_*      config      write enable     cfg_index (3b), cfg_data (25b)
//
// A request runs through the accept state S_IDLE and then 13 sequencer steps per
// channel. The step count is set by the one shared 21x26 multiply-accumulate,
// which does eight products per channel, around the glide, address and
// delay-line read steps. The last step stalls while an earlier result is
// still waiting on the output register. After reset no clearing pass runs:
// a fill flag and the write position mark which line entries read as zero.

module stereo_feedback_echo #(
	parameter int LINE_DEPTH = sfe_pkg::LINE_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sfe_in_if.sink                             samples,
	sfe_out_if.source                          mixed,
	input  logic                               cfg_write,
	input  logic [sfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW    = $clog2(LINE_DEPTH);
	localparam int IW    = ((AW > 16) ? AW : 16) + 1;	// address arithmetic, with sign
	localparam int MA_W  = 21;	// multiplier operand A, signed
	localparam int MB_W  = 26;	// multiplier operand B, signed (unsigned value)
	localparam int P_W   = MA_W + MB_W;
	localparam int ACC_W = 48;
	localparam int SW    = sfe_pkg::SAMPLE_W;
	localparam int DW    = sfe_pkg::DELAY_W;
	localparam int TW    = sfe_pkg::TARGET_W;

	// upper delay clamp; beyond 24 bits it never bites
	localparam longint HI_FULL = (longint'(LINE_DEPTH) - 1) * 256;
	localparam logic [TW-1:0] TGT_HI = (HI_FULL > 64'hFFFFFF) ? 24'hFFFFFF : TW'(HI_FULL);
	localparam logic [TW-1:0] TGT_RST =
		(sfe_pkg::DELAY_TARGET_RST < sfe_pkg::TARGET_MIN) ? sfe_pkg::TARGET_MIN :
		(sfe_pkg::DELAY_TARGET_RST > TGT_HI) ? TGT_HI : sfe_pkg::DELAY_TARGET_RST;
	localparam logic [DW-1:0] NOW_RST = {TGT_RST, 16'd0};

	localparam logic signed [ACC_W-1:0] ROUND23 = ACC_W'(64'd8388608);
	localparam logic signed [ACC_W-1:0] ROUND14 = ACC_W'(64'd16384);

	// one-hot sequencer
	typedef enum logic [13:0] {
		S_IDLE  = 14'h0001,
		S_DIFF  = 14'h0002,
		S_G_LO  = 14'h0004,
		S_G_HI  = 14'h0008,
		S_G_UPD = 14'h0010,
		S_ADDR  = 14'h0020,
		S_RD0   = 14'h0040,
		S_RD1   = 14'h0080,
		S_I1    = 14'h0100,
		S_WA    = 14'h0200,
		S_WB    = 14'h0400,
		S_OA    = 14'h0800,
		S_OB    = 14'h1000,
		S_FIN   = 14'h2000
	} state_t;

	typedef enum logic [1:0] {
		B_ZERO,
		B_ACC,
		B_ACC_SHR,
		B_RND
	} base_t;

	function automatic logic signed [SW-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] s;
		s = v >>> 15;
		if (s > 32767)
			return 16'sh7FFF;
		if (s < -32768)
			return -16'sh8000;
		return s[SW-1:0];
	endfunction

	// config registers
	logic [TW-1:0]                   target_q [2];
	logic [sfe_pkg::GAIN_W-1:0]      fb_q;
	logic [sfe_pkg::GAIN_W-1:0]      wet_q;
	logic [sfe_pkg::COEFF_W-1:0]     glide_q;

	// control state
	state_t                          state_q;
	logic                            ch_q;
	logic [AW-1:0]                   wp_q;
	logic                            full_q;
	logic [DW-1:0]                   now_q [2];
	logic                            out_valid_q;

	// datapath registers
	logic signed [SW-1:0]            in_q [2];
	logic signed [SW-1:0]            res_l_q;
	logic signed [SW-1:0]            out_l_q;
	logic signed [SW-1:0]            out_r_q;
	logic [DW-1:0]                   diff_q;
	logic                            neg_q;
	logic [AW-1:0]                   i0_q;
	logic [AW-1:0]                   i1_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [SW-1:0]            d_q;
	logic signed [SW-1:0]            rd_l_q;
	logic signed [SW-1:0]            rd_r_q;
	logic                            rd_ok_q;

	// delay lines
	logic signed [SW-1:0]            left_line  [LINE_DEPTH];
	logic signed [SW-1:0]            right_line [LINE_DEPTH];

	// combinational
	logic [TW-1:0]                   tgt_c;
	logic [DW-1:0]                   tgt40;
	logic [sfe_pkg::COEFF_W-1:0]     coeff_c;
	logic [sfe_pkg::GAIN_W:0]        fb_c;
	logic [sfe_pkg::GAIN_W:0]        wet_c;
	logic [DW-1:0]                   now_c;
	logic [DW-1:0]                   step_c;
	logic [15:0]                     n_c;
	logic [sfe_pkg::COEFF_W-1:0]     frac_c;
	logic [IW-1:0]                   i0_raw;
	logic [IW-1:0]                   i1_raw;
	logic [IW-1:0]                   i0_fix;
	logic [IW-1:0]                   i1_fix;
	logic signed [SW-1:0]            x_c;
	logic [AW-1:0]                   rd_addr;
	logic signed [MA_W-1:0]          mul_a;
	logic [sfe_pkg::COEFF_W-1:0]     mul_bu;
	logic signed [MB_W-1:0]          mul_b;
	logic signed [P_W-1:0]           prod;
	base_t                           base_sel;
	logic signed [ACC_W-1:0]         base_c;
	logic                            acc_en;
	logic signed [SW-1:0]            res_c;
	logic                            load_out;
	logic                            line_we;

	assign samples.ready   = (state_q == S_IDLE);
	assign mixed.valid     = out_valid_q;
	assign mixed.left_out  = out_l_q;
	assign mixed.right_out = out_r_q;

	// clamps
	always_comb begin
		tgt_c = target_q[ch_q];
		if (tgt_c < sfe_pkg::TARGET_MIN)
			tgt_c = sfe_pkg::TARGET_MIN;
		else if (tgt_c > TGT_HI)
			tgt_c = TGT_HI;
	end
	assign tgt40   = {tgt_c, 16'd0};
	assign coeff_c = (glide_q > sfe_pkg::ONE_Q24) ? sfe_pkg::ONE_Q24 : glide_q;
	assign fb_c    = ({1'b0, fb_q} > sfe_pkg::ONE_Q15) ? sfe_pkg::ONE_Q15 : {1'b0, fb_q};
	assign wet_c   = ({1'b0, wet_q} > sfe_pkg::ONE_Q15) ? sfe_pkg::ONE_Q15 : {1'b0, wet_q};

	assign now_c  = now_q[ch_q];
	assign step_c = acc_q[DW+3:4];	// floor of total / 2^24
	assign n_c    = now_c[DW-1:24];
	assign frac_c = {1'b0, now_c[23:0]};

	// read taps: n and n+1 frames back, wrapped into the line
	assign i0_raw = IW'(wp_q) - IW'(n_c);
	assign i1_raw = i0_raw - IW'(1);
	assign i0_fix = i0_raw[IW-1] ? i0_raw + IW'(LINE_DEPTH) : i0_raw;
	assign i1_fix = i1_raw[IW-1] ? i1_raw + IW'(LINE_DEPTH) : i1_raw;

	// unwritten entries read as zero
	assign x_c = !rd_ok_q ? '0 : (ch_q ? rd_r_q : rd_l_q);

	assign rd_addr = (state_q == S_RD1) ? i1_q : i0_q;

	// shared multiply-accumulate operand selection
	always_comb begin
		mul_a    = '0;
		mul_bu   = '0;
		base_sel = B_ZERO;
		acc_en   = 1'b0;
		unique case (state_q)
			S_G_LO: begin
				mul_a  = {1'b0, diff_q[19:0]};
				mul_bu = coeff_c;
				acc_en = 1'b1;
			end
			S_G_HI: begin
				mul_a    = {1'b0, diff_q[DW-1:20]};
				mul_bu   = coeff_c;
				base_sel = B_ACC_SHR;
				acc_en   = 1'b1;
			end
			S_RD1: begin
				mul_a    = {{(MA_W-SW){x_c[SW-1]}}, x_c};
				mul_bu   = sfe_pkg::ONE_Q24 - frac_c;
				base_sel = B_RND;
				acc_en   = 1'b1;
			end
			S_I1: begin
				mul_a    = {{(MA_W-SW){x_c[SW-1]}}, x_c};
				mul_bu   = frac_c;
				base_sel = B_ACC;
				acc_en   = 1'b1;
			end
			S_WA: begin
				mul_a    = {{(MA_W-SW){in_q[ch_q][SW-1]}}, in_q[ch_q]};
				mul_bu   = {8'd0, sfe_pkg::ONE_Q15};
				base_sel = B_RND;
				acc_en   = 1'b1;
			end
			S_WB: begin
				mul_a    = {{(MA_W-SW){d_q[SW-1]}}, d_q};
				mul_bu   = {8'd0, fb_c};
				base_sel = B_ACC;
				acc_en   = 1'b1;
			end
			S_OA: begin
				mul_a    = {{(MA_W-SW){in_q[ch_q][SW-1]}}, in_q[ch_q]};
				mul_bu   = {8'd0, sfe_pkg::ONE_Q15 - wet_c};
				base_sel = B_RND;
				acc_en   = 1'b1;
			end
			S_OB: begin
				mul_a    = {{(MA_W-SW){d_q[SW-1]}}, d_q};
				mul_bu   = {8'd0, wet_c};
				base_sel = B_ACC;
				acc_en   = 1'b1;
			end
			S_IDLE, S_DIFF, S_G_UPD, S_ADDR, S_RD0, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign mul_b = {1'b0, mul_bu};
	assign prod  = mul_a * mul_b;

	always_comb begin
		unique case (base_sel)
			B_ZERO:    base_c = '0;
			B_ACC:     base_c = acc_q;
			B_ACC_SHR: base_c = acc_q >>> 20;
			B_RND:     base_c = (state_q == S_RD1) ? ROUND23 : ROUND14;
			default:   base_c = '0;
		endcase
	end

	assign res_c    = sat16(acc_q);
	assign load_out = (state_q == S_FIN) && ch_q && (!out_valid_q || mixed.ready);
	assign line_we  = (state_q == S_OA);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q[0] <= sfe_pkg::DELAY_TARGET_RST;
			target_q[1] <= sfe_pkg::DELAY_TARGET_RST;
			fb_q        <= sfe_pkg::FEEDBACK_GAIN_RST;
			wet_q       <= sfe_pkg::WET_MIX_RST;
			glide_q     <= sfe_pkg::GLIDE_COEFF_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sfe_pkg::REG_LEFT_DELAY_TARGET:  target_q[0] <= cfg_data[TW-1:0];
				sfe_pkg::REG_RIGHT_DELAY_TARGET: target_q[1] <= cfg_data[TW-1:0];
				sfe_pkg::REG_FEEDBACK_GAIN:      fb_q        <= cfg_data[sfe_pkg::GAIN_W-1:0];
				sfe_pkg::REG_WET_MIX:            wet_q       <= cfg_data[sfe_pkg::GAIN_W-1:0];
				sfe_pkg::REG_GLIDE_COEFF:        glide_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			wp_q        <= '0;
			full_q      <= 1'b0;
			now_q[0]    <= NOW_RST;
			now_q[1]    <= NOW_RST;
			out_valid_q <= 1'b0;
		end else begin
			// a new frame into the output register wins over the drain
			if (load_out)
				out_valid_q <= 1'b1;
			else if (mixed.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						ch_q    <= 1'b0;
						state_q <= S_DIFF;
					end
				end
				S_DIFF:  state_q <= S_G_LO;
				S_G_LO:  state_q <= S_G_HI;
				S_G_HI:  state_q <= S_G_UPD;
				S_G_UPD: begin
					now_q[ch_q] <= neg_q ? now_c - step_c : now_c + step_c;
					state_q     <= S_ADDR;
				end
				S_ADDR:  state_q <= S_RD0;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_I1;
				S_I1:    state_q <= S_WA;
				S_WA:    state_q <= S_WB;
				S_WB:    state_q <= S_OA;
				S_OA:    state_q <= S_OB;
				S_OB:    state_q <= S_FIN;
				S_FIN: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_DIFF;
					end else if (load_out) begin
						state_q <= S_IDLE;
						if (wp_q == AW'(LINE_DEPTH - 1)) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			in_q[0] <= samples.left_in;
			in_q[1] <= samples.right_in;
		end
		if (state_q == S_DIFF) begin
			neg_q  <= tgt40 < now_c;
			diff_q <= (tgt40 < now_c) ? now_c - tgt40 : tgt40 - now_c;
		end
		if (state_q == S_ADDR) begin
			i0_q <= i0_fix[AW-1:0];
			i1_q <= i1_fix[AW-1:0];
		end
		if (acc_en)
			acc_q <= base_c + ACC_W'(prod);
		if (state_q == S_WA)
			d_q <= acc_q[39:24];
		if (state_q == S_FIN && !ch_q)
			res_l_q <= res_c;
		if (load_out) begin
			out_l_q <= res_l_q;
			out_r_q <= res_c;
		end
		rd_ok_q <= full_q || (rd_addr < wp_q);
	end

	// delay line memories: one registered read, one write
	always_ff @(posedge clk) begin
		rd_l_q <= left_line[rd_addr];
		if (line_we && !ch_q)
			left_line[wp_q] <= sat16(acc_q);
	end

	always_ff @(posedge clk) begin
		rd_r_q <= right_line[rd_addr];
		if (line_we && ch_q)
			right_line[wp_q] <= sat16(acc_q);
	end

	// a request makes the block busy on the next cycle
	`SFE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, samples.valid && samples.ready, !samples.ready)
	// gliding delays never fall below one whole sample
	`SFE_ASSERT_IMPL(a_delay_floor, clk, arst_n, 1'b1, now_q[0][DW-1:24] != '0 && now_q[1][DW-1:24] != '0)
	// every frame loaded into the output register advances the write position
	`SFE_ASSERT_NEXT(a_wp_advance, clk, arst_n, load_out, wp_q != $past(wp_q) && out_valid_q)

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for stereo_feedback_echo: random stereo frames in bursts, a stalling
// receiver, and a bit-exact echo predictor checked against every mixed frame.
// Depends on sfe_pkg, sfe_in_if, sfe_out_if and the stereo_feedback_echo RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = sfe_pkg::LINE_DEPTH_DEFAULT;
	// largest usable delay, Q16.8
	localparam logic [sfe_pkg::TARGET_W-1:0] TARGET_MAX = sfe_pkg::TARGET_W'((DEPTH - 1) * 256);
	// indexes past the last register: writes there must change nothing
	localparam logic [sfe_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = sfe_pkg::REG_GLIDE_COEFF + 3'd1;
	localparam logic [sfe_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = '1;
	localparam longint ROUND_Q15 = 64'sd16384;
	localparam longint ROUND_Q24 = 64'sd8388608;
	localparam int RANDOM_FRAMES = 1130;
	localparam int QUIET_LIMIT = 2000;	// time per request plus worst stall and gap, many times over

	typedef struct packed {
		logic signed [sfe_pkg::SAMPLE_W-1:0] left_smp;
		logic signed [sfe_pkg::SAMPLE_W-1:0] right_smp;
	} stereo_frame_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [sfe_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data;

	sfe_in_if samples_ch ();
	sfe_out_if mixed_ch ();

	stereo_feedback_echo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.mixed    (mixed_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Echo predictor: own copy of the delay lines, glide state and
	// registers. Index 0 is the left channel, 1 the right.
	// ------------------------------------------------------------------
	logic signed [sfe_pkg::SAMPLE_W-1:0] line_mem [2][DEPTH];
	logic [sfe_pkg::DELAY_W-1:0]         delay_now [2];
	logic [15:0]                         wr_pos;
	logic [sfe_pkg::TARGET_W-1:0]        target_reg [2];
	logic [sfe_pkg::GAIN_W-1:0]          feedback_reg;
	logic [sfe_pkg::GAIN_W-1:0]          wet_reg;
	logic [sfe_pkg::COEFF_W-1:0]         glide_reg;

	function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[sfe_pkg::SAMPLE_W-1:0];
	endfunction

	// out-of-range targets are pulled back into 1..DEPTH-1 samples
	function automatic logic [sfe_pkg::TARGET_W-1:0] clamp_target(
			logic [sfe_pkg::TARGET_W-1:0] t);
		if (t < sfe_pkg::TARGET_MIN)
			return sfe_pkg::TARGET_MIN;
		if (t > TARGET_MAX)
			return TARGET_MAX;
		return t;
	endfunction

	// one channel: glide, interpolated read, feedback write, dry/wet mix
	function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] echo_channel(int ch,
			logic signed [sfe_pkg::SAMPLE_W-1:0] smp);
		logic [sfe_pkg::DELAY_W-1:0] goal;
		logic [79:0]                 prod;
		logic [sfe_pkg::COEFF_W-1:0] c;
		logic [15:0]                 n;
		logic [15:0]                 i0;
		logic [15:0]                 i1;
		logic [23:0]                 f;
		longint                      acc;
		longint                      d;
		longint                      fb;
		longint                      wet;
		goal = {clamp_target(target_reg[ch]), 16'd0};
		c = (glide_reg > sfe_pkg::ONE_Q24) ? sfe_pkg::ONE_Q24 : glide_reg;
		// step size truncated toward zero in both directions
		if (goal >= delay_now[ch]) begin
			prod = 80'(goal - delay_now[ch]) * 80'(c);
			delay_now[ch] = delay_now[ch] + prod[63:24];
		end else begin
			prod = 80'(delay_now[ch] - goal) * 80'(c);
			delay_now[ch] = delay_now[ch] - prod[63:24];
		end
		n = delay_now[ch][39:24];
		f = delay_now[ch][23:0];
		// read before write: at the longest delay i1 lands on the slot being replaced
		i0 = wr_pos - n;
		i1 = wr_pos - n - 16'd1;
		acc = longint'(line_mem[ch][i0]) * (longint'(sfe_pkg::ONE_Q24) - longint'(f))
			+ longint'(line_mem[ch][i1]) * longint'(f) + ROUND_Q24;
		d = acc >>> 24;
		fb = (feedback_reg > sfe_pkg::ONE_Q15) ? longint'(sfe_pkg::ONE_Q15)
			: longint'(feedback_reg);
		wet = (wet_reg > sfe_pkg::ONE_Q15) ? longint'(sfe_pkg::ONE_Q15) : longint'(wet_reg);
		acc = longint'(smp) * longint'(sfe_pkg::ONE_Q15) + d * fb + ROUND_Q15;
		line_mem[ch][wr_pos] = clip16(acc >>> 15);
		acc = longint'(smp) * (longint'(sfe_pkg::ONE_Q15) - wet) + d * wet + ROUND_Q15;
		return clip16(acc >>> 15);
	endfunction

	function automatic stereo_frame_t echo_frame(stereo_frame_t x);
		stereo_frame_t y;
		y.left_smp = echo_channel(0, x.left_smp);
		y.right_smp = echo_channel(1, x.right_smp);
		wr_pos = wr_pos + 16'd1;
		return y;
	endfunction

	// ------------------------------------------------------------------
	// Queues and counters
	// ------------------------------------------------------------------
	stereo_frame_t frames_queued [$];	// waiting for the driver
	stereo_frame_t pending_mix [$];	// predicted, not yet seen at the output
	int frames_offered = 0;
	int frames_taken = 0;
	int mixes_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int pattern_age = 0;

	// ------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge. Output check
	// first; a request accepted on the same edge cannot be the one whose
	// result is leaving, given the block's latency.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		stereo_frame_t want;
		bit busy;
		busy = 1'b0;
		if (arst_n) begin
			if (mixed_ch.valid && mixed_ch.ready) begin
				busy = 1'b1;
				if (pending_mix.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected mixed frame, expected none, actual %0d / %0d",
						$time, mixed_ch.left_out, mixed_ch.right_out);
				end else begin
					want = pending_mix.pop_front();
					mixes_checked++;
					if (mixed_ch.left_out !== want.left_smp) begin
						mismatches++;
						$display("%0t: left_out expected %0d actual %0d", $time,
							want.left_smp, mixed_ch.left_out);
					end
					if (mixed_ch.right_out !== want.right_smp) begin
						mismatches++;
						$display("%0t: right_out expected %0d actual %0d", $time,
							want.right_smp, mixed_ch.right_out);
					end
				end
			end
			if (samples_ch.valid && samples_ch.ready) begin
				busy = 1'b1;
				frames_taken++;
				pending_mix.push_back(echo_frame({samples_ch.left_in, samples_ch.right_in}));
			end
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Driver: requests go out in bursts with random gaps; a request is
	// held until the rising edge that takes it.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : driver
		stereo_frame_t nxt;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
		end else if (!(samples_ch.valid && frames_taken != frames_offered)) begin
			if (gap_left > 0) begin
				gap_left--;
				samples_ch.valid <= 1'b0;
			end else if (frames_queued.size() > 0) begin
				nxt = frames_queued.pop_front();
				samples_ch.left_in <= nxt.left_smp;
				samples_ch.right_in <= nxt.right_smp;
				samples_ch.valid <= 1'b1;
				frames_offered++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					// a quarter of bursts run straight on with no gap
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready follows a rotating pattern, reloaded each time pattern_age wraps;
	// all-ones stretches give runs with no back-pressure.
	always @(negedge clk) begin : receiver
		logic [15:0] pat;
		pat = {ready_pattern[0], ready_pattern[15:1]};
		pattern_age++;
		if (pattern_age >= 48) begin
			pattern_age = 0;
			case ($urandom_range(0, 3))
				0: pat = 16'hFFFF;
				1: pat = 16'($urandom | 32'h0001);
				default: pat = 16'(($urandom & $urandom) | 32'h0001);
			endcase
		end
		ready_pattern = pat;
		mixed_ch.ready <= pat[0];
	end

	// watchdog: nothing accepted for too long ends the run
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("stereo_feedback_echo verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [sfe_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sfe_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			sfe_pkg::REG_LEFT_DELAY_TARGET:  target_reg[0] = val[sfe_pkg::TARGET_W-1:0];
			sfe_pkg::REG_RIGHT_DELAY_TARGET: target_reg[1] = val[sfe_pkg::TARGET_W-1:0];
			sfe_pkg::REG_FEEDBACK_GAIN:      feedback_reg = val[sfe_pkg::GAIN_W-1:0];
			sfe_pkg::REG_WET_MIX:            wet_reg = val[sfe_pkg::GAIN_W-1:0];
			sfe_pkg::REG_GLIDE_COEFF:        glide_reg = val[sfe_pkg::COEFF_W-1:0];
			default: ;	// spare index, ignored
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait until every request is in and every mixed frame checked;
	// every request yields a frame, so the block is idle then
	task automatic settle();
		while (frames_queued.size() != 0 || frames_taken != frames_offered
				|| pending_mix.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_frame(input int l, input int r);
		stereo_frame_t x;
		x.left_smp = l[sfe_pkg::SAMPLE_W-1:0];
		x.right_smp = r[sfe_pkg::SAMPLE_W-1:0];
		frames_queued.push_back(x);
	endtask

	function automatic int pick_sample();
		case ($urandom_range(0, 9))
			6, 7: return int'($urandom_range(0, 511)) - 256;
			8: return $urandom_range(0, 1) ? 32767 : -32768;
			9: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// mostly short echoes so the feedback path gets exercised
	function automatic logic [sfe_pkg::CFG_DATA_W-1:0] pick_target();
		case ($urandom_range(0, 9))
			7: return sfe_pkg::CFG_DATA_W'($urandom & 32'h00FF_FFFF);
			8: return sfe_pkg::CFG_DATA_W'($urandom_range(0, 255));
			9: return sfe_pkg::CFG_DATA_W'(TARGET_MAX + $urandom_range(1, 255));
			default: return sfe_pkg::CFG_DATA_W'($urandom_range(256, 64 * 256));
		endcase
	endfunction

	function automatic logic [sfe_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return sfe_pkg::CFG_DATA_W'(sfe_pkg::ONE_Q15);
			2: return sfe_pkg::CFG_DATA_W'($urandom_range(32769, 65535));
			default: return sfe_pkg::CFG_DATA_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int n_frames;
		int random_sent;
		logic [sfe_pkg::CFG_DATA_W-1:0] coeff;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.left_in = '0;
		samples_ch.right_in = '0;
		mixed_ch.ready = 1'b0;

		foreach (line_mem[c, k])
			line_mem[c][k] = '0;
		wr_pos = '0;
		target_reg[0] = sfe_pkg::DELAY_TARGET_RST;
		target_reg[1] = sfe_pkg::DELAY_TARGET_RST;
		feedback_reg = sfe_pkg::FEEDBACK_GAIN_RST;
		wet_reg = sfe_pkg::WET_MIX_RST;
		glide_reg = sfe_pkg::GLIDE_COEFF_RST;
		delay_now[0] = {clamp_target(sfe_pkg::DELAY_TARGET_RST), 16'd0};
		delay_now[1] = {clamp_target(sfe_pkg::DELAY_TARGET_RST), 16'd0};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: long delay, lines still empty; sample extremes
		settings_used++;
		push_frame(0, 0);
		push_frame(32767, -32768);
		push_frame(-32768, 32767);
		push_frame(-1, 1);
		settle();

		// targets below and above range, gains and glide above one, spare indexes
		write_reg(sfe_pkg::REG_LEFT_DELAY_TARGET, '0);
		write_reg(sfe_pkg::REG_RIGHT_DELAY_TARGET, 25'h0FF_FFFF);
		write_reg(sfe_pkg::REG_FEEDBACK_GAIN, 25'h000_FFFF);
		write_reg(sfe_pkg::REG_WET_MIX, 25'h000_FFFF);
		write_reg(sfe_pkg::REG_GLIDE_COEFF, 25'h1FF_FFFF);
		for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++)
			write_reg(k[sfe_pkg::CFG_INDEX_W-1:0], sfe_pkg::CFG_DATA_W'($urandom));
		@(posedge clk);
		settings_used++;
		// unity feedback on the left channel's one-sample delay drives its line into saturation
		repeat (4) push_frame(32767, 32767);
		repeat (3) push_frame(-32768, -32768);
		repeat (2) push_frame(0, 0);
		settle();

		// zero glide: delays hold where they are, targets ignored
		write_reg(sfe_pkg::REG_LEFT_DELAY_TARGET, sfe_pkg::CFG_DATA_W'(2 * 256 + 128));
		write_reg(sfe_pkg::REG_RIGHT_DELAY_TARGET, sfe_pkg::CFG_DATA_W'(3 * 256 + 1));
		write_reg(sfe_pkg::REG_FEEDBACK_GAIN, sfe_pkg::CFG_DATA_W'(sfe_pkg::ONE_Q15));
		write_reg(sfe_pkg::REG_WET_MIX, '0);
		write_reg(sfe_pkg::REG_GLIDE_COEFF, '0);
		@(posedge clk);
		settings_used++;
		push_frame(32767, -32768);
		repeat (4) push_frame(0, 0);
		push_frame(-32768, 12345);
		settle();

		// glide of exactly one: jump straight to fractional targets, fully wet
		write_reg(sfe_pkg::REG_GLIDE_COEFF, sfe_pkg::ONE_Q24);
		write_reg(sfe_pkg::REG_WET_MIX, sfe_pkg::CFG_DATA_W'(sfe_pkg::ONE_Q15));
		write_reg(sfe_pkg::REG_FEEDBACK_GAIN, '0);
		@(posedge clk);
		settings_used++;
		push_frame(20000, -20000);
		repeat (4) push_frame(0, 0);
		settle();

		// random phases, each with its own settings
		random_sent = 0;
		while (random_sent < RANDOM_FRAMES) begin
			write_reg(sfe_pkg::REG_LEFT_DELAY_TARGET, pick_target());
			write_reg(sfe_pkg::REG_RIGHT_DELAY_TARGET, pick_target());
			write_reg(sfe_pkg::REG_FEEDBACK_GAIN, pick_gain());
			write_reg(sfe_pkg::REG_WET_MIX, pick_gain());
			case ($urandom_range(0, 7))
				0: coeff = sfe_pkg::ONE_Q24;
				1: coeff = '0;
				2: coeff = sfe_pkg::CFG_DATA_W'($urandom_range(sfe_pkg::ONE_Q24 + 1,
					2 * sfe_pkg::ONE_Q24 - 1));
				3, 4: coeff = sfe_pkg::CFG_DATA_W'($urandom_range(0, 4096));
				default: coeff = sfe_pkg::CFG_DATA_W'($urandom_range(0, sfe_pkg::ONE_Q24));
			endcase
			write_reg(sfe_pkg::REG_GLIDE_COEFF, coeff);
			if ($urandom_range(0, 3) == 0)
				write_reg(sfe_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					sfe_pkg::CFG_DATA_W'($urandom));
			@(posedge clk);
			settings_used++;
			n_frames = $urandom_range(60, 140);
			for (int k = 0; k < n_frames; k++)
				push_frame(pick_sample(), pick_sample());
			random_sent += n_frames;
			settle();
		end

		repeat (30) @(posedge clk);
		$display("Run covered %0d stereo requests across %0d register settings.",
			frames_taken, settings_used);
		$display("%0d mixed frames compared, %0d field mismatches.", mixes_checked, mismatches);
		if (mismatches == 0 && pending_mix.size() == 0)
			$display("stereo_feedback_echo verification clean");
		else
			$display("stereo_feedback_echo verification failed");
		$finish;
	end

endmodule
